### rtl/sdi12_line_transceiver_assert.svh
// Assertion macros for the SDI-12 line transceiver.
`ifndef SDI12_LINE_TRANSCEIVER_ASSERT_SVH
`define SDI12_LINE_TRANSCEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDI12_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDI12_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sdi12_pkg.sv
// Types, codes and helpers shared by the SDI-12 line transceiver modules.
package sdi12_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_BEGIN  = 3'd1,
    OP_SEND   = 3'd2,
    OP_FINISH = 3'd3,
    OP_RECV   = 3'd4,
    OP_IDLE   = 3'd5
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BREAK   = 2'd0,
    CFG_MARKING = 2'd1,
    CFG_BIT     = 2'd2
  } cfg_idx_e;

  // Bus mode
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_SEND   = 4'b0010,
    MODE_FRAME  = 4'b0100,
    MODE_LISTEN = 4'b1000
  } mode_e;

  // Command preamble phase
  typedef enum logic [3:0] {
    PH_NONE  = 4'b0001,
    PH_BREAK = 4'b0010,
    PH_MARK  = 4'b0100,
    PH_READY = 4'b1000
  } phase_e;

  // Encoded bus mode as seen on the result
  localparam logic [1:0] BUS_IDLE   = 2'd0;
  localparam logic [1:0] BUS_SEND   = 2'd1;
  localparam logic [1:0] BUS_FRAME  = 2'd2;
  localparam logic [1:0] BUS_LISTEN = 2'd3;

  localparam logic [15:0] BREAK_TICKS_RST   = 16'd13000;
  localparam logic [15:0] MARKING_TICKS_RST = 16'd9000;
  localparam logic [15:0] BIT_TICKS_RST     = 16'd833;

  localparam logic [6:0] CHAR_CR = 7'h0D;
  localparam logic [6:0] CHAR_LF = 7'h0A;

  // Transmit side status after the current request
  typedef struct packed {
    logic       line_level;
    logic       drive_enable;
    logic       tx_ready;
    logic       rejected;
    logic [1:0] bus_mode;
  } tx_status_t;

  // Control from the transmit side to the receive side
  typedef struct packed {
    logic listen;  // currently listening
    logic clear;   // finish taken: restart the receive buffer
  } ctrl_rx_t;

  // Receive side result of the current request
  typedef struct packed {
    logic       valid;
    logic       rejected;
    logic [6:0] rx_char;
    logic [6:0] rx_index;
    logic       first_char;
    logic       end_of_line;
  } rx_result_t;

  function automatic logic [1:0] mode_to_bus(mode_e m);
    logic [1:0] b;
    case (m)
      MODE_IDLE:   b = BUS_IDLE;
      MODE_SEND:   b = BUS_SEND;
      MODE_FRAME:  b = BUS_FRAME;
      MODE_LISTEN: b = BUS_LISTEN;
      default:     b = BUS_IDLE;
    endcase
    return b;
  endfunction

endpackage

### rtl/sdi12_line_transceiver.sv
// Top level of the SDI-12 line transceiver: config registers and result register.
// One request per cycle: a request is taken whenever the result register is empty
// or its result is being taken in the same cycle, and its result appears in the
// result register on the next cycle. The whole update of the bus state for one
// request is one pass of logic between the state registers and the result
// register, so without stalls the rate is one request per clock. All timing
// (break, marking, bit length) counts tick requests, not clock cycles. There is
// no clearing pass after reset. Config registers take a write every cycle.
`include "sdi12_line_transceiver_assert.svh"

module sdi12_line_transceiver
  import sdi12_pkg::*;
#(
  parameter int RX_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_char_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_level_o,
  output logic        drive_enable_o,
  output logic        tx_ready_o,
  output logic        rejected_o,
  output logic        rx_valid_o,
  output logic [6:0]  rx_char_o,
  output logic [6:0]  rx_index_o,
  output logic        first_char_o,
  output logic        end_of_line_o,
  output logic [1:0]  bus_mode_o
);

  logic [15:0] break_ticks_q;
  logic [15:0] marking_ticks_q;
  logic [15:0] bit_ticks_q;
  logic        accept;
  logic        res_valid_q;
  tx_status_t  tx_status;
  ctrl_rx_t    rx_ctl;
  rx_result_t  rx_res;
  tx_status_t  tx_q;
  rx_result_t  rx_q;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_ticks_q   <= BREAK_TICKS_RST;
      marking_ticks_q <= MARKING_TICKS_RST;
      bit_ticks_q     <= BIT_TICKS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BREAK:   break_ticks_q   <= cfg_data_i;
        CFG_MARKING: marking_ticks_q <= cfg_data_i;
        CFG_BIT:     bit_ticks_q     <= cfg_data_i;
        default: begin
          // index outside the register list: no effect
        end
      endcase
    end
  end

  // Request transfer whenever the result slot frees up
  assign in_ready_o = !res_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  sdi12_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .op_i            (op_i),
    .data_char_i     (data_char_i),
    .break_ticks_i   (break_ticks_q),
    .marking_ticks_i (marking_ticks_q),
    .bit_ticks_i     (bit_ticks_q),
    .status_o        (tx_status),
    .rx_ctl_o        (rx_ctl)
  );

  sdi12_rx #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op_i),
    .data_char_i (data_char_i),
    .rx_ctl_i    (rx_ctl),
    .result_o    (rx_res)
  );

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      res_valid_q <= in_valid_i;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q <= tx_status;
      rx_q <= rx_res;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign line_level_o   = tx_q.line_level;
  assign drive_enable_o = tx_q.drive_enable;
  assign tx_ready_o     = tx_q.tx_ready;
  assign rejected_o     = tx_q.rejected | rx_q.rejected;
  assign rx_valid_o     = rx_q.valid;
  assign rx_char_o      = rx_q.rx_char;
  assign rx_index_o     = rx_q.rx_index;
  assign first_char_o   = rx_q.first_char;
  assign end_of_line_o  = rx_q.end_of_line;
  assign bus_mode_o     = tx_q.bus_mode;

  // Checks
  `SDI12_ASSERT_IMPL(a_rx_only_listening, out_valid_o && rx_valid_o,
    !rejected_o && !drive_enable_o && (bus_mode_o == BUS_LISTEN),
    "received char outside listening")
  `SDI12_ASSERT_IMPL(a_ready_in_send, out_valid_o && tx_ready_o,
    drive_enable_o && (bus_mode_o == BUS_SEND), "tx ready outside send mode")
  `SDI12_ASSERT_IMPL(a_first_at_zero, out_valid_o && first_char_o,
    rx_valid_o && (rx_index_o == 7'd0), "first char not at index zero")
  `SDI12_ASSERT_IMPL(a_eol_is_lf, out_valid_o && end_of_line_o,
    rx_valid_o && (rx_char_o == CHAR_LF), "end of line flagged on non-LF")

endmodule

### rtl/sdi12_ctrl.sv
// Transmit sequencer: mode, break and marking timing, 7E1 frame shifting.
module sdi12_ctrl
  import sdi12_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_char_i,
  input  logic [15:0] break_ticks_i,
  input  logic [15:0] marking_ticks_i,
  input  logic [15:0] bit_ticks_i,
  output tx_status_t  status_o,
  output ctrl_rx_t    rx_ctl_o
);

  mode_e       mode_q, mode_d;
  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [3:0]  bits_q, bits_d;
  logic [9:0]  shift_q, shift_d;
  logic        pin_q, pin_d;
  logic        rej;
  logic        clear;
  logic        ready;
  logic        timing;
  logic [9:0]  frame;

  assign ready = (mode_q == MODE_SEND) && (phase_q == PH_READY);

  // Counter runs during break, marking and a frame
  assign timing = (mode_q == MODE_FRAME) ||
                  ((mode_q == MODE_SEND) && ((phase_q == PH_BREAK) || (phase_q == PH_MARK)));

  // Frame with inverted levels: start high, data 1 low, even parity, stop low
  assign frame = {1'b0, ~(^data_char_i[6:0]), ~data_char_i[6:0], 1'b1};

  // Next state
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    tick_d  = tick_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    pin_d   = pin_q;
    rej     = 1'b0;
    clear   = 1'b0;
    case (op_e'(op_i))
      OP_TICK: begin
        if (timing) begin
          if (tick_q > 16'd1) begin
            tick_d = tick_q - 16'd1;
          end else if (mode_q == MODE_SEND) begin
            if (phase_q == PH_BREAK) begin
              phase_d = PH_MARK;
              pin_d   = 1'b0;
              tick_d  = marking_ticks_i;
            end else begin
              phase_d = PH_READY;
              tick_d  = '0;
            end
          end else if (bits_q != 4'd0) begin
            pin_d   = shift_q[0];
            shift_d = {1'b0, shift_q[9:1]};
            bits_d  = bits_q - 4'd1;
            tick_d  = bit_ticks_i;
          end else begin
            mode_d  = MODE_SEND;
            phase_d = PH_READY;
            tick_d  = '0;
            pin_d   = 1'b0;
          end
        end
      end
      OP_BEGIN: begin
        if (mode_q == MODE_IDLE) begin
          mode_d  = MODE_SEND;
          phase_d = PH_BREAK;
          pin_d   = 1'b1;
          tick_d  = break_ticks_i;
        end else begin
          rej = 1'b1;
        end
      end
      OP_SEND: begin
        if (ready) begin
          mode_d  = MODE_FRAME;
          pin_d   = frame[0];
          shift_d = {1'b0, frame[9:1]};
          bits_d  = 4'd9;
          tick_d  = bit_ticks_i;
        end else begin
          rej = 1'b1;
        end
      end
      OP_FINISH: begin
        if (ready) begin
          mode_d  = MODE_LISTEN;
          phase_d = PH_NONE;
          tick_d  = '0;
          pin_d   = 1'b0;
          clear   = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      OP_RECV: begin
        // handled on the receive side
      end
      OP_IDLE: begin
        mode_d  = MODE_IDLE;
        phase_d = PH_NONE;
        tick_d  = '0;
        bits_d  = '0;
        shift_d = '0;
        pin_d   = 1'b0;
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PH_NONE;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      pin_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      pin_q   <= pin_d;
    end
  end

  // Status reflects the state after this request
  assign status_o.line_level   = pin_d;
  assign status_o.drive_enable = (mode_d == MODE_SEND) || (mode_d == MODE_FRAME);
  assign status_o.tx_ready     = (mode_d == MODE_SEND) && (phase_d == PH_READY);
  assign status_o.rejected     = rej;
  assign status_o.bus_mode     = mode_to_bus(mode_d);

  assign rx_ctl_o.listen = (mode_q == MODE_LISTEN);
  assign rx_ctl_o.clear  = clear;

endmodule

### rtl/sdi12_rx.sv
// Receive side: seven-bit masking, wrapping index, first char and CR-LF flags.
module sdi12_rx
  import sdi12_pkg::*;
#(
  parameter int RX_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] op_i,
  input  logic [7:0] data_char_i,
  input  ctrl_rx_t   rx_ctl_i,
  output rx_result_t result_o
);

  localparam int IDX_W = $clog2(RX_DEPTH);
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(RX_DEPTH);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [6:0]       prev_q, prev_d;
  logic [IDX_W:0]   idx_inc;
  logic [6:0]       ch;
  logic             is_recv;
  logic             take;

  assign ch      = data_char_i[6:0];
  assign is_recv = (op_e'(op_i) == OP_RECV);
  assign take    = is_recv && rx_ctl_i.listen;
  assign idx_inc = {1'b0, idx_q} + 1'b1;

  // Index and previous character update
  always_comb begin
    idx_d  = idx_q;
    prev_d = prev_q;
    if (take) begin
      prev_d = ch;
      idx_d  = (idx_inc >= DEPTH_L) ? '0 : idx_inc[IDX_W-1:0];
    end else if (rx_ctl_i.clear) begin
      idx_d  = '0;
      prev_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      prev_q <= '0;
    end else if (accept_i) begin
      idx_q  <= idx_d;
      prev_q <= prev_d;
    end
  end

  // Result fields other than rejected read zero unless a character was taken
  assign result_o.valid       = take;
  assign result_o.rejected    = is_recv && !rx_ctl_i.listen;
  assign result_o.rx_char     = take ? ch : '0;
  assign result_o.rx_index    = take ? 7'(idx_q) : '0;
  assign result_o.first_char  = take && (idx_q == '0);
  assign result_o.end_of_line = take && (prev_q == CHAR_CR) && (ch == CHAR_LF);

endmodule
